// ----- hw/rtl/pbead_pkg.sv -----
// ----------------------------------------------------------------------------
// pbead_pkg
// Shared types, register codes and reset values for the power, battery and
// environment alert debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbead_pkg;

  localparam int unsigned IN_BYTES  = 7;
  localparam int unsigned OUT_BYTES = 5;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STABLE_SAMPLES = 3'd0,
    CFG_LOW_BATT_PCT   = 3'd1,
    CFG_REARM_PCT      = 3'd2,
    CFG_TEMP_THR_X10   = 3'd3,
    CFG_HUM_THR_PCT    = 3'd4,
    CFG_TEMP_HYST_X10  = 3'd5,
    CFG_HUM_HYST_PCT   = 3'd6
  } cfg_index_t;

  // charger phase codes
  typedef enum logic [1:0] {
    PH_OTHER     = 2'd0,
    PH_PRECHARGE = 2'd1,
    PH_FAST      = 2'd2,
    PH_DONE      = 2'd3
  } charge_phase_t;

  localparam logic [3:0]         RST_STABLE_SAMPLES = 4'd3;
  localparam logic [6:0]         RST_LOW_BATT_PCT   = 7'd30;
  localparam logic [6:0]         RST_REARM_PCT      = 7'd35;
  localparam logic signed [11:0] RST_TEMP_THR_X10   = 12'sd300;
  localparam logic [6:0]         RST_HUM_THR_PCT    = 7'd70;
  localparam logic [7:0]         RST_TEMP_HYST_X10  = 8'd10;
  localparam logic [6:0]         RST_HUM_HYST_PCT   = 7'd5;

  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic [3:0] next;
    logic       hit;
  } cnt_res_t;

  // saturating confirm counter: increments below the limit, confirms and
  // clears once at or above it
  function automatic cnt_res_t count_up(input logic [3:0] c, input logic [3:0] limit);
    cnt_res_t   r;
    logic [3:0] v;
    v = c;
    if (c < limit) v = c + 4'd1;
    if (v >= limit) begin
      r.next = 4'd0;
      r.hit  = 1'b1;
    end else begin
      r.next = v;
      r.hit  = 1'b0;
    end
    return r;
  endfunction

  // clamp a signed 9-bit percent to 0..100
  function automatic logic [6:0] clamp_pct(input logic signed [8:0] v);
    logic [6:0] r;
    if (v <= 9'sd0) r = 7'd0;
    else if (v >= 9'sd100) r = PCT_MAX;
    else r = v[6:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/power_battery_env_alert_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// power_battery_env_alert_debouncer_top
// Four qualified event detectors (power, charge, low battery, environment)
// run on one sensor snapshot per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_*  : one sensor snapshot per request (fields listed at the port).
//   m_axis_*  : one result per snapshot: event flags, payloads, latch states.
//   cfg_*     : register writes; cfg_ready is always high. Write only while
//               the block holds no undelivered result.
// Result: an accepted snapshot's update is captured in the result register and presented on m_axis from there.
// Throughput: one snapshot per cycle unless a held result stalls the input;
//   the detector update is a single pass of compares and 4-bit counter steps
//   between the input port and the result register.
// Stall: the result register holds while m_axis_tready is low and
//   s_axis_tready drops with it; a new request is taken in the same cycle the
//   held result leaves.
// Reset (rst, synchronous): registers return to their defaults, all detector
//   counters and latches clear, no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module power_battery_env_alert_debouncer_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // charger_ok[0], ext_present[1], charge_phase[3:2], battery_ok[4],
  // battery_voltage_mv[20:5], soc_percent[29:21], env_ok[30],
  // temperature[42:31], humidity_percent[51:43], zero[55:52]
  input  wire logic [pbead_pkg::IN_BYTES*8-1:0]    s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // power_in_event[0], power_out_event[1], charge_done_event[2],
  // low_battery_event[3], low_battery_level[10:4], env_alert_event[11],
  // alert_temperature[23:12], alert_humidity[30:24], power_stable[31],
  // low_batt_latched[32], env_alert_latched[33], zero[39:34]
  output logic [pbead_pkg::OUT_BYTES*8-1:0]        m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [11:0]                         cfg_data
);

  // configuration
  logic [3:0]         stable_samples;
  logic [6:0]         low_battery_percent;
  logic [6:0]         rearm_percent;
  logic signed [11:0] temp_threshold_x10;
  logic [6:0]         hum_threshold_percent;
  logic [7:0]         temp_hyst_x10;
  logic [6:0]         hum_hyst_percent;

  // detector state
  logic       power_seen_once, stable_power, pwr_cand;
  logic [3:0] power_count;
  logic       chg_seen, chg_reported;
  logic [3:0] done_count;
  logic       low_batt_latch;
  logic [3:0] low_batt_count;
  logic       env_latch;
  logic [3:0] env_high_count, env_clear_count;

  logic       power_seen_once_next, stable_power_next, pwr_cand_next;
  logic [3:0] power_count_next;
  logic       chg_seen_next, chg_reported_next;
  logic [3:0] done_count_next;
  logic       low_batt_latch_next;
  logic [3:0] low_batt_count_next;
  logic       env_latch_next;
  logic [3:0] env_high_count_next, env_clear_count_next;

  // result register fields
  logic              p_in, p_out, c_done, lb_ev, env_ev;
  logic [6:0]        lb_lvl, a_hum;
  logic signed [11:0] a_temp;
  logic              p_in_next, p_out_next, c_done_next, lb_ev_next, env_ev_next;
  logic [6:0]        lb_lvl_next, a_hum_next;
  logic signed [11:0] a_temp_next;

  logic out_valid;
  logic s_accept;

  // input fields
  logic               chg_ok, present, bat_ok, e_ok;
  logic [1:0]         phase;
  logic signed [15:0] mv;
  logic signed [11:0] temp;
  logic [6:0]         soc, hum;

  assign chg_ok  = s_axis_tdata[0];
  assign present = s_axis_tdata[1];
  assign phase   = s_axis_tdata[3:2];
  assign bat_ok  = s_axis_tdata[4];
  assign mv      = s_axis_tdata[20:5];
  assign soc     = pbead_pkg::clamp_pct(s_axis_tdata[29:21]);
  assign e_ok    = s_axis_tdata[30];
  assign temp    = s_axis_tdata[42:31];
  assign hum     = pbead_pkg::clamp_pct(s_axis_tdata[51:43]);

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // environment compares, widened so nothing wraps
  logic               env_high, env_clear;
  logic signed [13:0] temp_clr_lvl;
  logic signed [8:0]  hum_clr_lvl;

  assign temp_clr_lvl = 14'(temp_threshold_x10) - $signed({6'd0, temp_hyst_x10});
  assign hum_clr_lvl  = $signed({2'b00, hum_threshold_percent})
                      - $signed({2'b00, hum_hyst_percent});
  assign env_high  = (temp >= temp_threshold_x10) || (hum >= hum_threshold_percent);
  assign env_clear = (14'(temp) <= temp_clr_lvl) &&
                     ($signed({2'b00, hum}) <= hum_clr_lvl);

  pbead_pkg::cnt_res_t power_cnt, done_cnt, lb_cnt, env_hi_cnt, env_clr_cnt;

  assign power_cnt   = pbead_pkg::count_up(power_count, stable_samples);
  assign done_cnt    = pbead_pkg::count_up(done_count, stable_samples);
  assign lb_cnt      = pbead_pkg::count_up(low_batt_count, stable_samples);
  assign env_hi_cnt  = pbead_pkg::count_up(env_high_count, stable_samples);
  assign env_clr_cnt = pbead_pkg::count_up(env_clear_count, stable_samples);

  always_comb begin
    power_seen_once_next = power_seen_once;
    stable_power_next    = stable_power;
    pwr_cand_next        = pwr_cand;
    power_count_next     = power_count;
    chg_seen_next        = chg_seen;
    done_count_next      = done_count;
    chg_reported_next    = chg_reported;
    low_batt_count_next  = low_batt_count;
    low_batt_latch_next  = low_batt_latch;
    env_high_count_next  = env_high_count;
    env_clear_count_next = env_clear_count;
    env_latch_next       = env_latch;
    p_in_next   = 1'b0;
    p_out_next  = 1'b0;
    c_done_next = 1'b0;
    lb_ev_next  = 1'b0;
    env_ev_next = 1'b0;
    lb_lvl_next = 7'd0;
    a_temp_next = 12'sd0;
    a_hum_next  = 7'd0;

    // power
    if (!chg_ok) begin
      power_count_next = 4'd0;
    end else if (!power_seen_once) begin
      // first valid sample sets the stable value silently
      power_seen_once_next = 1'b1;
      stable_power_next    = present;
      pwr_cand_next        = present;
      power_count_next     = 4'd0;
    end else if (present == stable_power) begin
      pwr_cand_next    = present;
      power_count_next = 4'd0;
    end else if (present != pwr_cand) begin
      pwr_cand_next    = present;
      power_count_next = 4'd1;
    end else begin
      power_count_next = power_cnt.next;
      if (power_cnt.hit) begin
        stable_power_next = present;
        p_in_next         = present;
        p_out_next        = !present;
      end
    end

    // charge
    if (!chg_ok) begin
      done_count_next = 4'd0;
    end else if (!present) begin
      chg_seen_next     = 1'b0;
      done_count_next   = 4'd0;
      chg_reported_next = 1'b0;
    end else if (phase == pbead_pkg::PH_PRECHARGE || phase == pbead_pkg::PH_FAST) begin
      chg_seen_next     = 1'b1;
      done_count_next   = 4'd0;
      chg_reported_next = 1'b0;
    end else if (phase != pbead_pkg::PH_DONE || !chg_seen || chg_reported) begin
      done_count_next = 4'd0;
    end else begin
      done_count_next = done_cnt.next;
      if (done_cnt.hit) begin
        chg_reported_next = 1'b1;
        c_done_next       = 1'b1;
      end
    end

    // battery; nonpositive voltage counts as an invalid reading
    if (!bat_ok || mv <= 16'sd0) begin
      low_batt_count_next = 4'd0;
    end else if (low_batt_latch) begin
      if (soc >= rearm_percent) low_batt_latch_next = 1'b0;
    end else if (soc >= low_battery_percent) begin
      low_batt_count_next = 4'd0;
    end else begin
      low_batt_count_next = lb_cnt.next;
      if (lb_cnt.hit) begin
        low_batt_latch_next = 1'b1;
        lb_ev_next          = 1'b1;
        lb_lvl_next         = soc;
      end
    end

    // environment
    if (!e_ok) begin
      env_high_count_next  = 4'd0;
      env_clear_count_next = 4'd0;
    end else if (env_latch) begin
      env_high_count_next = 4'd0;
      if (!env_clear) begin
        env_clear_count_next = 4'd0;
      end else begin
        env_clear_count_next = env_clr_cnt.next;
        if (env_clr_cnt.hit) env_latch_next = 1'b0;
      end
    end else begin
      env_clear_count_next = 4'd0;
      if (!env_high) begin
        env_high_count_next = 4'd0;
      end else begin
        env_high_count_next = env_hi_cnt.next;
        if (env_hi_cnt.hit) begin
          env_latch_next = 1'b1;
          env_ev_next    = 1'b1;
          a_temp_next    = temp;
          a_hum_next     = hum;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_samples        <= pbead_pkg::RST_STABLE_SAMPLES;
      low_battery_percent   <= pbead_pkg::RST_LOW_BATT_PCT;
      rearm_percent         <= pbead_pkg::RST_REARM_PCT;
      temp_threshold_x10    <= pbead_pkg::RST_TEMP_THR_X10;
      hum_threshold_percent <= pbead_pkg::RST_HUM_THR_PCT;
      temp_hyst_x10         <= pbead_pkg::RST_TEMP_HYST_X10;
      hum_hyst_percent      <= pbead_pkg::RST_HUM_HYST_PCT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbead_pkg::CFG_STABLE_SAMPLES: stable_samples        <= cfg_data[3:0];
        pbead_pkg::CFG_LOW_BATT_PCT:   low_battery_percent   <= cfg_data[6:0];
        pbead_pkg::CFG_REARM_PCT:      rearm_percent         <= cfg_data[6:0];
        pbead_pkg::CFG_TEMP_THR_X10:   temp_threshold_x10    <= cfg_data;
        pbead_pkg::CFG_HUM_THR_PCT:    hum_threshold_percent <= cfg_data[6:0];
        pbead_pkg::CFG_TEMP_HYST_X10:  temp_hyst_x10         <= cfg_data[7:0];
        pbead_pkg::CFG_HUM_HYST_PCT:   hum_hyst_percent      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      power_seen_once <= 1'b0;
      stable_power    <= 1'b0;
      pwr_cand        <= 1'b0;
      power_count     <= 4'd0;
      chg_seen        <= 1'b0;
      done_count      <= 4'd0;
      chg_reported    <= 1'b0;
      low_batt_count  <= 4'd0;
      low_batt_latch  <= 1'b0;
      env_high_count  <= 4'd0;
      env_clear_count <= 4'd0;
      env_latch       <= 1'b0;
    end else if (s_accept) begin
      power_seen_once <= power_seen_once_next;
      stable_power    <= stable_power_next;
      pwr_cand        <= pwr_cand_next;
      power_count     <= power_count_next;
      chg_seen        <= chg_seen_next;
      done_count      <= done_count_next;
      chg_reported    <= chg_reported_next;
      low_batt_count  <= low_batt_count_next;
      low_batt_latch  <= low_batt_latch_next;
      env_high_count  <= env_high_count_next;
      env_clear_count <= env_clear_count_next;
      env_latch       <= env_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      p_in   <= p_in_next;
      p_out  <= p_out_next;
      c_done <= c_done_next;
      lb_ev  <= lb_ev_next;
      lb_lvl <= lb_lvl_next;
      env_ev <= env_ev_next;
      a_temp <= a_temp_next;
      a_hum  <= a_hum_next;
    end
  end

  // latch states read back from the state registers, which only move on accept
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, env_latch, low_batt_latch, stable_power, a_hum,
                          a_temp, env_ev, lb_lvl, lb_ev, c_done, p_out, p_in};

`ifndef SYNTHESIS
  a_lb_event_latches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lb_ev) |-> low_batt_latch)
    else $error("low battery event without latch");

  a_env_event_latches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && env_ev) |-> env_latch)
    else $error("environment event without latch");

  a_power_event_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!(p_in && p_out) && (!p_in || stable_power) &&
                   (!p_out || !stable_power)))
    else $error("power event disagrees with stable power");

  a_lb_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !lb_ev) |-> (lb_lvl == 7'd0))
    else $error("low battery level without event");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> ($stable(env_latch) && $stable(low_batt_latch)
                                       && $stable(stable_power)))
    else $error("state moved while result stalled");
`endif

endmodule

`default_nettype wire
